// ===== design/smp_pkg.sv =====
`timescale 1ns / 1ps

package smp_pkg;

   localparam int unsigned DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 3;
   localparam int unsigned BITS_WIDTH = 5;
   localparam int unsigned HALF_COUNT_WIDTH = 8;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_WRITE_DATA = 2'd1;
   localparam logic [1:0] CMD_READ_DATA = 2'd2;
   localparam logic [1:0] CMD_READ_STATUS = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BAUD_CODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLOCK_POLARITY = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLOCK_PHASE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LSB_FIRST = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_16BIT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ENABLE = 3'd5;

   typedef struct packed {
      logic [2:0] baud_code;
      logic       clock_polarity;
      logic       clock_phase;
      logic       lsb_first;
      logic       frame_16bit;
      logic       enable;
   } cfg_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  sclk;
      logic                  mosi;
      logic                  tx_empty;
      logic                  rx_ready;
      logic                  busy_res;
      logic                  overrun;
   } result_type;

endpackage

// ===== design/smp_cfg.sv =====
`timescale 1ns / 1ps

module smp_cfg
   import smp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_BAUD_CODE:      cfg_in.baud_code = csr_write_data;
            REG_CLOCK_POLARITY: cfg_in.clock_polarity = csr_write_data[0];
            REG_CLOCK_PHASE:    cfg_in.clock_phase = csr_write_data[0];
            REG_LSB_FIRST:      cfg_in.lsb_first = csr_write_data[0];
            REG_FRAME_16BIT:    cfg_in.frame_16bit = csr_write_data[0];
            REG_ENABLE:         cfg_in.enable = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/smp_core.sv =====
`timescale 1ns / 1ps

module smp_core
   import smp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  fire,
   input  logic [1:0]            cmd,
   input  logic [DATA_WIDTH-1:0] write_data,
   input  logic                  miso,
   output result_type            result
);

   logic [DATA_WIDTH-1:0]       tx_buffer_ff, tx_buffer_in;
   logic                        tx_full_ff, tx_full_in;
   logic [DATA_WIDTH-1:0]       shift_reg_ff, shift_reg_in;
   logic [DATA_WIDTH-1:0]       rx_buffer_ff, rx_buffer_in;
   logic                        rx_full_ff, rx_full_in;
   logic                        overrun_ff, overrun_in;
   logic [BITS_WIDTH-1:0]       bits_left_ff, bits_left_in;
   logic [HALF_COUNT_WIDTH-1:0] half_count_ff, half_count_in;
   logic                        clock_level_ff, clock_level_in;
   logic                        shifting_ff, shifting_in;
   logic                        read_seen_ff, read_seen_in;
   logic                        mosi_ff, mosi_in;

   logic [DATA_WIDTH-1:0]       frame_mask;
   logic [BITS_WIDTH-1:0]       frame_width;
   logic [HALF_COUNT_WIDTH-1:0] half_period;
   logic [HALF_COUNT_WIDTH-1:0] count_inc;
   logic                        leading;
   logic                        sample;
   logic [DATA_WIDTH-1:0]       shifted;
   logic [DATA_WIDTH-1:0]       start_frame;
   logic                        out_bit_cur;
   logic                        out_bit_start;
   logic [DATA_WIDTH-1:0]       read_data;

   always_comb begin
      frame_mask  = cfg.frame_16bit ? 16'hFFFF : 16'h00FF;
      frame_width = cfg.frame_16bit ? 5'd16 : 5'd8;
      half_period = HALF_COUNT_WIDTH'(1) << cfg.baud_code;
      count_inc   = half_count_ff + 8'd1;
      leading     = (clock_level_ff == cfg.clock_polarity);
      sample      = leading ^ cfg.clock_phase;
      start_frame = tx_buffer_ff & frame_mask;
      out_bit_cur = cfg.lsb_first ? shift_reg_ff[0]
                  : (cfg.frame_16bit ? shift_reg_ff[15] : shift_reg_ff[7]);
      out_bit_start = cfg.lsb_first ? start_frame[0]
                    : (cfg.frame_16bit ? start_frame[15] : start_frame[7]);
      if (cfg.lsb_first) begin
         shifted = cfg.frame_16bit ? {miso, shift_reg_ff[15:1]}
                                   : {8'h00, miso, shift_reg_ff[7:1]};
      end else begin
         shifted = cfg.frame_16bit ? {shift_reg_ff[14:0], miso}
                                   : {8'h00, shift_reg_ff[6:0], miso};
      end
   end

   always_comb begin
      tx_buffer_in   = tx_buffer_ff;
      tx_full_in     = tx_full_ff;
      shift_reg_in   = shift_reg_ff;
      rx_buffer_in   = rx_buffer_ff;
      rx_full_in     = rx_full_ff;
      overrun_in     = overrun_ff;
      bits_left_in   = bits_left_ff;
      half_count_in  = half_count_ff;
      clock_level_in = clock_level_ff;
      shifting_in    = shifting_ff;
      read_seen_in   = read_seen_ff;
      mosi_in        = mosi_ff;
      read_data      = '0;

      case (cmd)
         CMD_TICK: begin
            if (shifting_ff) begin
               half_count_in = count_inc;
               if (count_inc >= half_period) begin
                  half_count_in  = '0;
                  clock_level_in = ~clock_level_ff;
                  if (bits_left_ff != '0) begin
                     if (sample) begin
                        shift_reg_in = shifted;
                        bits_left_in = bits_left_ff - 5'd1;
                     end else begin
                        mosi_in = out_bit_cur;
                     end
                  end
                  if (!leading && bits_left_in == '0) begin
                     if (rx_full_ff) begin
                        overrun_in = 1'b1;
                     end else begin
                        rx_buffer_in = shift_reg_in & frame_mask;
                        rx_full_in   = 1'b1;
                     end
                     shifting_in    = 1'b0;
                     clock_level_in = cfg.clock_polarity;
                  end
               end
            end else if (tx_full_ff && cfg.enable) begin
               shift_reg_in   = start_frame;
               tx_full_in     = 1'b0;
               bits_left_in   = frame_width;
               half_count_in  = '0;
               clock_level_in = cfg.clock_polarity;
               shifting_in    = 1'b1;
               if (!cfg.clock_phase) begin
                  mosi_in = out_bit_start;
               end
            end
         end
         CMD_WRITE_DATA: begin
            tx_buffer_in = write_data & frame_mask;
            tx_full_in   = 1'b1;
         end
         CMD_READ_DATA: begin
            read_data    = rx_buffer_ff;
            rx_full_in   = 1'b0;
            read_seen_in = 1'b1;
         end
         default: begin
            if (read_seen_ff) begin
               overrun_in = 1'b0;
            end
            read_seen_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_buffer_ff   <= '0;
         tx_full_ff     <= 1'b0;
         shift_reg_ff   <= '0;
         rx_buffer_ff   <= '0;
         rx_full_ff     <= 1'b0;
         overrun_ff     <= 1'b0;
         bits_left_ff   <= '0;
         half_count_ff  <= '0;
         clock_level_ff <= 1'b0;
         shifting_ff    <= 1'b0;
         read_seen_ff   <= 1'b0;
         mosi_ff        <= 1'b0;
      end else if (fire) begin
         tx_buffer_ff   <= tx_buffer_in;
         tx_full_ff     <= tx_full_in;
         shift_reg_ff   <= shift_reg_in;
         rx_buffer_ff   <= rx_buffer_in;
         rx_full_ff     <= rx_full_in;
         overrun_ff     <= overrun_in;
         bits_left_ff   <= bits_left_in;
         half_count_ff  <= half_count_in;
         clock_level_ff <= clock_level_in;
         shifting_ff    <= shifting_in;
         read_seen_ff   <= read_seen_in;
         mosi_ff        <= mosi_in;
      end
   end

   always_comb begin
      result.read_data = read_data;
      result.sclk      = shifting_in ? clock_level_in : cfg.clock_polarity;
      result.mosi      = mosi_in;
      result.tx_empty  = ~tx_full_in;
      result.rx_ready  = rx_full_in;
      result.busy_res  = shifting_in | tx_full_in;
      result.overrun   = overrun_in;
   end

   bits_range_check: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= 5'd16)
      else $error("bit count out of range");

   idle_no_bits_check: assert property (@(posedge clock) disable iff (reset)
      fire && cmd == CMD_TICK && !shifting_ff && tx_full_ff && cfg.enable
      |=> shifting_ff && !tx_full_ff && bits_left_ff != '0)
      else $error("frame start did not load the shifter");

   overrun_set_check: assert property (@(posedge clock) disable iff (reset)
      $rose(overrun_ff) |-> $past(rx_full_ff) && $past(shifting_ff))
      else $error("overrun set without a full receive buffer");

endmodule

// ===== design/spi_master_peripheral_unit.sv =====
`timescale 1ns / 1ps
// A request passes through the input register and then the result register before its result is offered.
// Throughput: one request per cycle; stalls only when the result register is held.
// The serial clock half period is 2^baud_code tick requests, counted in the core.
// Reset (synchronous, active high) clears both stage valid bits, configuration and all SPI state.

module spi_master_peripheral_unit
   import smp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_cmd,
   input  logic [DATA_WIDTH-1:0]      req_write_data,
   input  logic                       req_miso,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DATA_WIDTH-1:0]      rsp_read_data,
   output logic                       rsp_sclk,
   output logic                       rsp_mosi,
   output logic                       rsp_tx_empty,
   output logic                       rsp_rx_ready,
   output logic                       rsp_busy_res,
   output logic                       rsp_overrun,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type               cfg;
   result_type            result;

   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            in_cmd_ff;
   logic [DATA_WIDTH-1:0] in_write_data_ff;
   logic                  in_miso_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff;

   logic                  advance;
   logic                  fire;
   logic                  req_take;

   smp_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   smp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (fire),
      .cmd        (in_cmd_ff),
      .write_data (in_write_data_ff),
      .miso       (in_miso_ff),
      .result     (result)
   );

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign fire      = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff        <= req_cmd;
         in_write_data_ff <= req_write_data;
         in_miso_ff       <= req_miso;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_sclk      = rsp_ff.sclk;
   assign rsp_mosi      = rsp_ff.mosi;
   assign rsp_tx_empty  = rsp_ff.tx_empty;
   assign rsp_rx_ready  = rsp_ff.rx_ready;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_overrun   = rsp_ff.overrun;

   fire_to_rsp_check: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("result register not loaded after fire");

   stall_cause_check: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without downstream backpressure");

   busy_status_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.tx_empty |-> rsp_ff.busy_res)
      else $error("pending frame not reported busy");

endmodule
